@@ rtl/tct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants of the task completion tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned PendW      = 5;
  localparam int unsigned CntRawW    = $clog2(TableDepth + 1);
  localparam int unsigned CntW       = (CntRawW > PendW) ? CntRawW : PendW;
  localparam int unsigned IdW        = 32;
  localparam int unsigned WorkW      = 32;
  localparam int unsigned StepsW     = 16;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 8;

  typedef enum logic [1:0] {
    CMD_SUBMIT  = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_ADVANCE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_COMPLETED = 2'd1,
    ST_CANCELLED = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [IdW-1:0]    id;
    status_e           status;
    logic [StepsW-1:0] countdown;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic              free;
    logic              upd;
    status_e           status;
    logic [StepsW-1:0] countdown;
    logic              pending;
  } cell_res_t;

endpackage

@@ rtl/task_completion_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_completion_tracker_unit
// Table of tracked tasks with submit, poll, cancel and advance commands.
// ----------------------------------------------------------------------------
// Per transaction, the sequencer walks the table one entry per cycle
// through a single shared compare/decrement unit, then, in the apply state,
// commits a submit or cancel and loads the result register once that
// register is free. The input is not ready during the walk.
// The result register lets the next command start while a result still
// waits. Valid bits clear at reset; no clearing pass is needed.
module task_completion_tracker_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tct_pkg::StepsW-1:0]      cfg_data_i,    // step count
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [tct_pkg::InDataW-1:0]     s_axis_tdata_i,  // task_id, work amount
  input  logic [1:0]                      s_axis_tuser_i,  // command
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [tct_pkg::OutDataW-1:0]    m_axis_tdata_o   // accepted, task_status,
                                                           // pending_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  state_e                        state_q;
  logic [tct_pkg::IdxW-1:0]      idx_q;
  tct_pkg::cmd_e                 cmd_q;
  logic [tct_pkg::IdW-1:0]       id_q;
  logic                          work_nz_q;
  logic                          hit_q;
  logic [tct_pkg::IdxW-1:0]      hit_idx_q;
  tct_pkg::status_e              hit_status_q;
  logic                          free_q;
  logic [tct_pkg::IdxW-1:0]      free_idx_q;
  logic [tct_pkg::CntW-1:0]      pend_q;
  logic [tct_pkg::StepsW-1:0]    steps_q;
  logic                          out_valid_q;
  logic [tct_pkg::OutDataW-1:0]  out_data_q;

  logic [tct_pkg::TableDepth-1:0] valid_q;
  logic [tct_pkg::IdW-1:0]        id_mem_q     [tct_pkg::TableDepth];
  tct_pkg::status_e               status_mem_q [tct_pkg::TableDepth];
  logic [tct_pkg::StepsW-1:0]     count_mem_q  [tct_pkg::TableDepth];

  tct_pkg::entry_t    cur_entry;
  tct_pkg::cell_res_t cell_res;

  logic                       in_fire;
  logic                       out_free;
  logic                       last_idx;
  logic                       submit_ok;
  logic                       cancel_ok;
  logic                       acc;
  tct_pkg::status_e           res_status;
  logic [tct_pkg::CntW-1:0]   pend_final;
  logic [tct_pkg::PendW-1:0]  pend_sat;
  logic [tct_pkg::StepsW-1:0] start_count;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign last_idx        = (idx_q == tct_pkg::IdxW'(tct_pkg::TableDepth - 1));

  always_comb begin
    cur_entry.valid     = valid_q[idx_q];
    cur_entry.id        = id_mem_q[idx_q];
    cur_entry.status    = status_mem_q[idx_q];
    cur_entry.countdown = count_mem_q[idx_q];
  end

  tct_cell_alu u_cell_alu (
    .entry_i   (cur_entry),
    .cmd_i     (cmd_q),
    .task_id_i (id_q),
    .res_o     (cell_res)
  );

  assign submit_ok = (cmd_q == tct_pkg::CMD_SUBMIT) && (id_q != '0) && work_nz_q
                     && !hit_q && free_q;
  assign cancel_ok = (cmd_q == tct_pkg::CMD_CANCEL) && hit_q
                     && (hit_status_q == tct_pkg::ST_PENDING);
  assign start_count = (steps_q == '0) ? tct_pkg::StepsW'(1) : steps_q;

  always_comb begin
    priority if (submit_ok) begin
      pend_final = pend_q + tct_pkg::CntW'(1);
    end else if (cancel_ok) begin
      pend_final = pend_q - tct_pkg::CntW'(1);
    end else begin
      pend_final = pend_q;
    end
    pend_sat = (pend_final > tct_pkg::CntW'(31)) ? tct_pkg::PendW'(31)
                                                 : pend_final[tct_pkg::PendW-1:0];
    unique case (cmd_q)
      tct_pkg::CMD_SUBMIT:  acc = submit_ok;
      tct_pkg::CMD_CANCEL:  acc = cancel_ok;
      default:              acc = 1'b1;
    endcase
    if (cmd_q == tct_pkg::CMD_POLL) begin
      res_status = hit_q ? hit_status_q : tct_pkg::ST_UNKNOWN;
    end else begin
      res_status = tct_pkg::ST_PENDING;
    end
  end

  // control and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      steps_q     <= tct_pkg::StepsW'(1);
      valid_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        steps_q <= cfg_data_i;
      end
      if ((state_q == S_APPLY) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_SCAN;
            idx_q   <= '0;
          end
        end
        S_SCAN: begin
          if (last_idx) begin
            state_q <= S_APPLY;
          end else begin
            idx_q <= idx_q + tct_pkg::IdxW'(1);
          end
        end
        S_APPLY: begin
          if (out_free) begin
            state_q <= S_IDLE;
            if (submit_ok) begin
              valid_q[free_idx_q] <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // transaction payload and scan results
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q     <= tct_pkg::cmd_e'(s_axis_tuser_i);
      id_q      <= s_axis_tdata_i[tct_pkg::IdW-1:0];
      work_nz_q <= (s_axis_tdata_i[tct_pkg::IdW +: tct_pkg::WorkW] != '0);
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      pend_q    <= '0;
    end
    if (state_q == S_SCAN) begin
      if (cell_res.hit) begin
        hit_q        <= 1'b1;
        hit_idx_q    <= idx_q;
        hit_status_q <= cur_entry.status;
      end
      if (cell_res.free && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= idx_q;
      end
      if (cell_res.pending) begin
        pend_q <= pend_q + tct_pkg::CntW'(1);
      end
    end
    if ((state_q == S_APPLY) && out_free) begin
      out_data_q <= {pend_sat, res_status, acc};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if ((state_q == S_SCAN) && cell_res.upd) begin
      status_mem_q[idx_q] <= cell_res.status;
      count_mem_q[idx_q]  <= cell_res.countdown;
    end
    if ((state_q == S_APPLY) && out_free) begin
      if (submit_ok) begin
        id_mem_q[free_idx_q]     <= id_q;
        status_mem_q[free_idx_q] <= tct_pkg::ST_PENDING;
        count_mem_q[free_idx_q]  <= start_count;
      end else if (cancel_ok) begin
        status_mem_q[hit_idx_q] <= tct_pkg::ST_CANCELLED;
      end
    end
  end

endmodule

@@ rtl/tct_cell_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_cell_alu
// Shared per-entry unit: id compare, free check and countdown update.
// ----------------------------------------------------------------------------
module tct_cell_alu (
  input  tct_pkg::entry_t          entry_i,
  input  tct_pkg::cmd_e            cmd_i,
  input  logic [tct_pkg::IdW-1:0]  task_id_i,
  output tct_pkg::cell_res_t       res_o
);

  logic is_pend;

  assign is_pend = entry_i.valid && (entry_i.status == tct_pkg::ST_PENDING);

  always_comb begin
    res_o.hit       = entry_i.valid && (entry_i.id == task_id_i);
    res_o.free      = !entry_i.valid;
    res_o.upd       = 1'b0;
    res_o.status    = entry_i.status;
    res_o.countdown = entry_i.countdown;
    if ((cmd_i == tct_pkg::CMD_ADVANCE) && is_pend) begin
      res_o.upd = 1'b1;
      if (entry_i.countdown <= tct_pkg::StepsW'(1)) begin
        res_o.countdown = '0;
        res_o.status    = tct_pkg::ST_COMPLETED;
      end else begin
        res_o.countdown = entry_i.countdown - tct_pkg::StepsW'(1);
      end
    end
    res_o.pending = entry_i.valid && (res_o.status == tct_pkg::ST_PENDING);
  end

endmodule

@@ tb/sv/task_completion_tracker_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_completion_tracker_unit_tb
// Self-checking bench for the task completion tracker. A small scoreboard
// tracks the task table, predicts accepted, task_status and pending_count for
// every command transaction, and checks each result in order. A directed
// opening covers rejected submits, unknown polls, failed cancels and
// completion, followed by random phases at several step counts with random
// gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module task_completion_tracker_unit_tb;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHold   = 600;
  localparam int unsigned DrainWait  = 2 * tct_pkg::TableDepth + 8;

  class tracker_scoreboard;
    typedef struct packed {
      logic                      accepted;
      tct_pkg::status_e          status;
      logic [tct_pkg::PendW-1:0] pending;
    } outcome_t;

    bit                         used[tct_pkg::TableDepth];
    logic [tct_pkg::IdW-1:0]    task_ids[tct_pkg::TableDepth];
    tct_pkg::status_e           states[tct_pkg::TableDepth];
    logic [tct_pkg::StepsW-1:0] countdowns[tct_pkg::TableDepth];
    logic [tct_pkg::StepsW-1:0] steps;
    outcome_t                   due_results[$];
    int unsigned                mismatches;

    function new();
      steps = 16'd1;
      mismatches = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void set_steps(logic [tct_pkg::StepsW-1:0] value);
      steps = value;
    endfunction

    function int find_task(logic [tct_pkg::IdW-1:0] id);
      for (int i = 0; i < tct_pkg::TableDepth; i++) begin
        if (used[i] && task_ids[i] == id) return i;
      end
      return -1;
    endfunction

    function int free_entry();
      for (int i = 0; i < tct_pkg::TableDepth; i++) begin
        if (!used[i]) return i;
      end
      return -1;
    endfunction

    function logic [tct_pkg::PendW-1:0] pending_tasks();
      int n;
      n = 0;
      for (int i = 0; i < tct_pkg::TableDepth; i++) begin
        if (used[i] && states[i] == tct_pkg::ST_PENDING) n++;
      end
      if (n > 31) n = 31;
      return n[tct_pkg::PendW-1:0];
    endfunction

    function void note_command(tct_pkg::cmd_e cmd, logic [tct_pkg::IdW-1:0] id,
                               logic [tct_pkg::WorkW-1:0] work);
      outcome_t o;
      int slot;
      o.accepted = 1'b0;
      o.status = tct_pkg::ST_PENDING;
      case (cmd)
        tct_pkg::CMD_SUBMIT: begin
          if (id != 0 && work != 0 && find_task(id) < 0) begin
            slot = free_entry();
            if (slot >= 0) begin
              used[slot] = 1'b1;
              task_ids[slot] = id;
              states[slot] = tct_pkg::ST_PENDING;
              countdowns[slot] = (steps == 0) ? 16'd1 : steps;
              o.accepted = 1'b1;
            end
          end
        end
        tct_pkg::CMD_POLL: begin
          o.accepted = 1'b1;
          slot = find_task(id);
          o.status = (slot < 0) ? tct_pkg::ST_UNKNOWN : states[slot];
        end
        tct_pkg::CMD_CANCEL: begin
          slot = find_task(id);
          if (slot >= 0 && states[slot] == tct_pkg::ST_PENDING) begin
            states[slot] = tct_pkg::ST_CANCELLED;
            o.accepted = 1'b1;
          end
        end
        default: begin
          o.accepted = 1'b1;
          for (int i = 0; i < tct_pkg::TableDepth; i++) begin
            if (used[i] && states[i] == tct_pkg::ST_PENDING) begin
              if (countdowns[i] <= 1) begin
                countdowns[i] = '0;
                states[i] = tct_pkg::ST_COMPLETED;
              end else begin
                countdowns[i] = countdowns[i] - 16'd1;
              end
            end
          end
        end
      endcase
      o.pending = pending_tasks();
      due_results.push_back(o);
    endfunction

    function void check_result(logic [tct_pkg::OutDataW-1:0] data);
      outcome_t o;
      if (due_results.size() == 0) begin
        $error("result 0x%02h arrived with no command outstanding", data);
        mismatches++;
        return;
      end
      o = due_results.pop_front();
      if (data[0] !== o.accepted) begin
        $error("accepted: expected %0d, got %0d", o.accepted, data[0]);
        mismatches++;
      end
      if (data[2:1] !== o.status) begin
        $error("task_status: expected %0d, got %0d", o.status, data[2:1]);
        mismatches++;
      end
      if (data[7:3] !== o.pending) begin
        $error("pending_count: expected %0d, got %0d", o.pending, data[7:3]);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [tct_pkg::StepsW-1:0]   cfg_data_i = '0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [tct_pkg::InDataW-1:0]  s_axis_tdata_i = '0;   // task_id, work amount
  logic [1:0]                   s_axis_tuser_i = '0;   // command
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [tct_pkg::OutDataW-1:0] m_axis_tdata_o;  // accepted, task_status, pending_count

  tracker_scoreboard          sb = new();
  logic [tct_pkg::IdW-1:0]    known_ids[$];
  bit                         hold_results = 1'b0;
  int unsigned                cycles = 0;

  task_completion_tracker_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // result side: random back-pressure, plus one long hold on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_results) begin
        m_axis_tready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_results = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready_i <= 1'b1;
        do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i) && !hold_results);
      end
    end
  end

  task automatic send_command(tct_pkg::cmd_e cmd, logic [tct_pkg::IdW-1:0] id,
                              logic [tct_pkg::WorkW-1:0] work, bit allow_gap);
    int unsigned gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {work, id};
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    sb.note_command(cmd, id, work);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_steps(logic [tct_pkg::StepsW-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sb.set_steps(value);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [tct_pkg::IdW-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70 && known_ids.size() > 0) return known_ids[$urandom_range(known_ids.size() - 1)];
    if (r < 80) return '0;
    return $urandom;
  endfunction

  task automatic run_phase(int unsigned count, int unsigned fresh_odds);
    int unsigned r;
    logic [tct_pkg::IdW-1:0] id;
    logic [tct_pkg::WorkW-1:0] work;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      work = ($urandom_range(9) == 0) ? '0 : $urandom;
      if (r < 40) begin
        send_command(tct_pkg::CMD_ADVANCE, $urandom, $urandom, 1'b1);
      end else if (r < 65) begin
        send_command(tct_pkg::CMD_POLL, pick_id(), work, 1'b1);
      end else if (r < 80) begin
        send_command(tct_pkg::CMD_CANCEL, pick_id(), work, 1'b1);
      end else begin
        if ($urandom_range(fresh_odds - 1) == 0) begin
          id = $urandom;
          known_ids.push_back(id);
        end else begin
          id = pick_id();
        end
        send_command(tct_pkg::CMD_SUBMIT, id, work, 1'b1);
      end
    end
  endtask

  initial begin
    logic [tct_pkg::IdW-1:0] id_a;
    logic [tct_pkg::IdW-1:0] id_b;
    logic [tct_pkg::IdW-1:0] id_c;
    id_a = 32'hFFFF_FFFF;
    id_b = 32'h0000_0001;
    id_c = 32'h8000_0000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening at the reset step count of one
    send_command(tct_pkg::CMD_POLL,    '0,            32'h0,         1'b0);
    send_command(tct_pkg::CMD_POLL,    id_a,          32'hFFFF_FFFF, 1'b0);
    send_command(tct_pkg::CMD_CANCEL,  '0,            32'h0,         1'b0);
    send_command(tct_pkg::CMD_SUBMIT,  '0,            32'd5,         1'b0);
    send_command(tct_pkg::CMD_SUBMIT,  id_a,          32'h0,         1'b0);
    send_command(tct_pkg::CMD_SUBMIT,  id_a,          32'hFFFF_FFFF, 1'b0);
    send_command(tct_pkg::CMD_SUBMIT,  id_a,          32'd1,         1'b0);
    send_command(tct_pkg::CMD_POLL,    id_a,          32'h0,         1'b0);
    send_command(tct_pkg::CMD_CANCEL,  32'h1234_5678, 32'h0,         1'b0);
    send_command(tct_pkg::CMD_SUBMIT,  id_b,          32'd1,         1'b0);
    send_command(tct_pkg::CMD_CANCEL,  id_b,          32'h0,         1'b0);
    send_command(tct_pkg::CMD_CANCEL,  id_b,          32'h0,         1'b0);
    send_command(tct_pkg::CMD_POLL,    id_b,          32'h0,         1'b0);
    send_command(tct_pkg::CMD_ADVANCE, 32'h0,         32'h0,         1'b0);
    send_command(tct_pkg::CMD_POLL,    id_a,          32'h0,         1'b0);
    send_command(tct_pkg::CMD_CANCEL,  id_a,          32'h0,         1'b0);
    send_command(tct_pkg::CMD_SUBMIT,  id_a,          32'd7,         1'b0);
    send_command(tct_pkg::CMD_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_command(tct_pkg::CMD_SUBMIT,  id_c,          32'h8000_0000, 1'b0);
    send_command(tct_pkg::CMD_POLL,    id_c,          32'h0,         1'b0);
    known_ids.push_back(id_a);
    known_ids.push_back(id_b);
    known_ids.push_back(id_c);

    write_steps(16'd0);
    run_phase(150, 8);

    write_steps(16'hFFFF);
    hold_results = 1'b1;
    run_phase(150, 8);

    write_steps(16'd2);
    run_phase(150, 8);

    write_steps(tct_pkg::StepsW'($urandom_range(9, 3)));
    run_phase(150, 6);

    write_steps(16'd5);
    run_phase(150, 4);

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ task_completion_tracker_unit.f @@
rtl/tct_pkg.sv
rtl/tct_cell_alu.sv
rtl/task_completion_tracker_unit.sv
tb/sv/task_completion_tracker_unit_tb.sv
